@@ sv/gms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types, sizes and codes for the Gaussian mixture sampler.
// ----------------------------------------------------------------------------
package gms_pkg;

  // table geometry
  localparam int NCOMP  = 8;
  localparam int NDIMS  = 4;
  localparam int COMP_W = 3;
  localparam int DIM_W  = 2;
  localparam int NC_W   = 4;
  localparam int ND_W   = 3;

  // data widths
  localparam int VALUE_W    = 24;
  localparam int NORM_W     = 16;
  localparam int UNIF_W     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int FACTOR_W   = 16;
  localparam int SUM_W      = 20;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 39;
  localparam int FRAC_SHIFT = 12;
  localparam int QUOT_W     = ACC_W - FRAC_SHIFT;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COMPONENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS       = 2'd1;

  // reset values and limits
  localparam logic [WEIGHT_W-1:0]        WEIGHT_RESET = 17'd65536;
  localparam logic [WEIGHT_W-1:0]        WEIGHT_MAX   = 17'd131071;
  localparam logic signed [FACTOR_W-1:0] FACTOR_DIAG  = 16'sd2867;
  localparam logic signed [FACTOR_W-1:0] FACTOR_MAX   = 16'sh7fff;
  localparam logic signed [FACTOR_W-1:0] FACTOR_MIN   = 16'sh8000;
  localparam logic signed [VALUE_W-1:0]  COORD_MAX    = 24'sh7fffff;
  localparam logic signed [VALUE_W-1:0]  COORD_MIN    = 24'sh800000;
  localparam logic signed [ACC_W-1:0]    ROUND_BIAS   = 39'sd2048;

  typedef enum logic [1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_MEAN   = 2'd1,
    CMD_LOAD_FACTOR = 2'd2,
    CMD_SAMPLE      = 2'd3
  } gms_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_MAC,
    ST_DONE
  } gms_state_t;

  typedef struct packed {
    gms_cmd_t                    cmd;
    logic [COMP_W-1:0]           component;
    logic [DIM_W-1:0]            row;
    logic [DIM_W-1:0]            col;
    logic signed [VALUE_W-1:0]   value;
    logic [UNIF_W-1:0]           uniform;
    logic signed [NORM_W-1:0]    normal_0;
    logic signed [NORM_W-1:0]    normal_1;
    logic signed [NORM_W-1:0]    normal_2;
    logic signed [NORM_W-1:0]    normal_3;
  } gms_in_t;

  typedef struct packed {
    logic [COMP_W-1:0]           chosen_component;
    logic signed [VALUE_W-1:0]   coord_0;
    logic signed [VALUE_W-1:0]   coord_1;
    logic signed [VALUE_W-1:0]   coord_2;
    logic signed [VALUE_W-1:0]   coord_3;
    logic                        saturated;
  } gms_out_t;

  // control from the sequencer to one dimension lane
  typedef struct packed {
    logic                        load_mean;
    logic                        load_factor;
    logic [COMP_W-1:0]           comp;
    logic [DIM_W-1:0]            col;
    logic signed [VALUE_W-1:0]   value;
    logic                        mac_en;
    logic                        mac_first;
    logic [COMP_W-1:0]           chosen;
    logic [DIM_W-1:0]            step;
  } gms_lane_ctrl_t;

endpackage

@@ sv/gms_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_select
// Weight table and component selection by running sum of weights.
// ----------------------------------------------------------------------------
module gms_select (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [gms_pkg::COMP_W-1:0] wr_comp,
  input  logic signed [gms_pkg::VALUE_W-1:0] wr_value,
  input  logic [gms_pkg::UNIF_W-1:0] uniform,
  input  logic [gms_pkg::NC_W-1:0]   nc_eff,
  output logic [gms_pkg::COMP_W-1:0] chosen
);
  import gms_pkg::*;

  logic [WEIGHT_W-1:0] weight_r [NCOMP];
  logic [WEIGHT_W-1:0] wr_weight;
  logic [SUM_W-1:0]    cum;
  logic                found;

  // weight load saturates to the unsigned range
  always_comb begin
    if (wr_value[VALUE_W-1]) begin
      wr_weight = '0;
    end else if (wr_value > VALUE_W'(WEIGHT_MAX)) begin
      wr_weight = WEIGHT_MAX;
    end else begin
      wr_weight = wr_value[WEIGHT_W-1:0];
    end
  end

  // weight table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCOMP; c++) begin
        weight_r[c] <= WEIGHT_RESET;
      end
    end else if (wr_en) begin
      weight_r[wr_comp] <= wr_weight;
    end
  end

  // first component whose running sum reaches the draw, else the last in use
  always_comb begin
    cum    = '0;
    found  = 1'b0;
    chosen = COMP_W'(nc_eff - NC_W'(1));
    for (int c = 0; c < NCOMP - 1; c++) begin
      cum = cum + SUM_W'(weight_r[c]);
      if (!found && (NC_W'(c + 1) < nc_eff) && (SUM_W'(uniform) <= cum)) begin
        found  = 1'b1;
        chosen = COMP_W'(c);
      end
    end
  end

endmodule

@@ sv/gms_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_lane
// One output dimension: mean and factor-row store, serial multiply-accumulate
// and rounding to Q12.12 with saturation.
// ----------------------------------------------------------------------------
module gms_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [gms_pkg::DIM_W-1:0]       lane_idx,
  input  gms_pkg::gms_lane_ctrl_t         ctrl,
  input  logic signed [gms_pkg::NORM_W-1:0]  normal,
  output logic signed [gms_pkg::VALUE_W-1:0] coord,
  output logic                            sat
);
  import gms_pkg::*;

  logic signed [VALUE_W-1:0]  mean_r   [NCOMP];
  logic signed [FACTOR_W-1:0] factor_r [NCOMP][NDIMS];
  logic signed [FACTOR_W-1:0] wr_factor;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    mean_ext;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [QUOT_W-1:0]   quot;

  // factor load saturates to 16 bits
  always_comb begin
    if (ctrl.value > VALUE_W'(FACTOR_MAX)) begin
      wr_factor = FACTOR_MAX;
    end else if (ctrl.value < VALUE_W'(FACTOR_MIN)) begin
      wr_factor = FACTOR_MIN;
    end else begin
      wr_factor = ctrl.value[FACTOR_W-1:0];
    end
  end

  // mean store for this dimension
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCOMP; c++) begin
        mean_r[c] <= '0;
      end
    end else if (ctrl.load_mean) begin
      mean_r[ctrl.comp] <= ctrl.value;
    end
  end

  // factor row store for this dimension, diagonal entry set at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCOMP; c++) begin
        for (int m = 0; m < NDIMS; m++) begin
          factor_r[c][m] <= (DIM_W'(m) == lane_idx) ? FACTOR_DIAG : '0;
        end
      end
    end else if (ctrl.load_factor) begin
      factor_r[ctrl.comp][ctrl.col] <= wr_factor;
    end
  end

  // one product per cycle, first step starts from the scaled mean
  always_comb begin
    prod     = factor_r[ctrl.chosen][ctrl.step] * normal;
    mean_ext = {{(ACC_W-VALUE_W-FRAC_SHIFT){mean_r[ctrl.chosen][VALUE_W-1]}},
                mean_r[ctrl.chosen], {FRAC_SHIFT{1'b0}}};
    acc_nxt  = (ctrl.mac_first ? mean_ext : acc_r)
             + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (ctrl.mac_en) begin
      acc_r <= acc_nxt;
    end
  end

  // round half up, then clip to 24 bits
  always_comb begin
    rnd  = acc_r + ROUND_BIAS;
    quot = rnd[ACC_W-1:FRAC_SHIFT];
    if (quot > QUOT_W'(COORD_MAX)) begin
      coord = COORD_MAX;
      sat   = 1'b1;
    end else if (quot < QUOT_W'(COORD_MIN)) begin
      coord = COORD_MIN;
      sat   = 1'b1;
    end else begin
      coord = quot[VALUE_W-1:0];
      sat   = 1'b0;
    end
  end

endmodule

@@ sv/gaussian_mixture_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_mixture_sampler
// Draws one point of a Gaussian mixture per sample beat: component selection
// by cumulative weight, then mean plus factor row times normals per dimension.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item, taken when in_valid is high and in_stall low.
//           Load beats (weight, mean, factor entry) write a table and
//           produce no result. A sample beat produces one result.
//   out_* : one result beat per sample, taken when out_valid is high and
//           out_stall low. The result register holds while stalled.
//   cfg_* : register writes (num_components, num_dims), taken whenever
//           cfg_valid is high; cfg_ready is always high. Write while idle.
// Sequence:
//   a sample passes a selection state, then one multiply-accumulate step per
//   dimension in use (one multiplier per dimension lane), then a done state
//   that loads the rounded result into the result register. No new beat is
//   taken until the sample has left the done state. Loads are taken back to
//   back.
// Reset: synchronous, active low; tables return to their default contents
//   at once (weights 1.0, means zero, factor diagonal 0.7), no clearing pass.
//   If out_stall holds a result, the finished sample waits in the done state.
// ----------------------------------------------------------------------------
module gaussian_mixture_sampler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gms_pkg::gms_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gms_pkg::gms_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gms_pkg::*;

  gms_state_t state_r, state_nxt;

  logic                      in_accept;
  logic                      out_free;
  logic                      capture;
  logic                      sel_load;
  logic                      mac_en;
  logic                      mac_first;
  logic                      out_load;
  logic                      last_step;

  logic [NC_W-1:0]           nc_r;
  logic [ND_W-1:0]           nd_r;
  logic [NC_W-1:0]           nc_eff;
  logic [ND_W-1:0]           nd_eff;

  gms_in_t                   item_r;
  logic [COMP_W-1:0]         chosen;
  logic [COMP_W-1:0]         chosen_r;
  logic [DIM_W-1:0]          step_r;
  logic [DIM_W-1:0]          step_nxt;

  logic signed [NORM_W-1:0]  normals [NDIMS];
  gms_lane_ctrl_t            lane_ctrl [NDIMS];
  logic signed [VALUE_W-1:0] lane_coord [NDIMS];
  logic                      lane_sat [NDIMS];
  logic signed [VALUE_W-1:0] coord_used [NDIMS];

  logic                      out_valid_r;
  gms_out_t                  out_data_r;
  gms_out_t                  out_nxt;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_W'(1);
      nd_r <= ND_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_COMPONENTS: nc_r <= cfg_data[NC_W-1:0];
        CFG_NUM_DIMS:       nd_r <= cfg_data[ND_W-1:0];
        default:            ;
      endcase
    end
  end

  // clamp to the supported range
  always_comb begin
    if (nc_r == '0) begin
      nc_eff = NC_W'(1);
    end else if (nc_r > NC_W'(NCOMP)) begin
      nc_eff = NC_W'(NCOMP);
    end else begin
      nc_eff = nc_r;
    end
    if (nd_r == '0) begin
      nd_eff = ND_W'(1);
    end else if (nd_r > ND_W'(NDIMS)) begin
      nd_eff = ND_W'(NDIMS);
    end else begin
      nd_eff = nd_r;
    end
  end

  assign last_step = (step_r == DIM_W'(nd_eff - ND_W'(1)));

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.cmd == CMD_SAMPLE) state_nxt = ST_SEL;
      end
      ST_SEL:  state_nxt = ST_MAC;
      ST_MAC: begin
        if (last_step) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    capture   = 1'b0;
    sel_load  = 1'b0;
    mac_en    = 1'b0;
    mac_first = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        capture  = in_accept && (in_data.cmd == CMD_SAMPLE);
      end
      ST_SEL:  sel_load = 1'b1;
      ST_MAC: begin
        mac_en    = 1'b1;
        mac_first = (step_r == '0);
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // product step counter
  always_comb begin
    step_nxt = step_r;
    if (sel_load) begin
      step_nxt = '0;
    end else if (mac_en && !last_step) begin
      step_nxt = step_r + DIM_W'(1);
    end
  end

  // sample beat and chosen component
  always_ff @(posedge clk) begin
    if (capture) begin
      item_r <= in_data;
    end
    if (sel_load) begin
      chosen_r <= chosen;
    end
  end

  gms_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_accept && in_data.cmd == CMD_LOAD_WEIGHT),
    .wr_comp  (in_data.component),
    .wr_value (in_data.value),
    .uniform  (item_r.uniform),
    .nc_eff   (nc_eff),
    .chosen   (chosen)
  );

  assign normals[0] = item_r.normal_0;
  assign normals[1] = item_r.normal_1;
  assign normals[2] = item_r.normal_2;
  assign normals[3] = item_r.normal_3;

  // per-lane control
  always_comb begin
    for (int k = 0; k < NDIMS; k++) begin
      lane_ctrl[k].load_mean   = in_accept && (in_data.cmd == CMD_LOAD_MEAN)
                               && (in_data.row == DIM_W'(k));
      lane_ctrl[k].load_factor = in_accept && (in_data.cmd == CMD_LOAD_FACTOR)
                               && (in_data.row == DIM_W'(k));
      lane_ctrl[k].comp        = in_data.component;
      lane_ctrl[k].col         = in_data.col;
      lane_ctrl[k].value       = in_data.value;
      lane_ctrl[k].mac_en      = mac_en;
      lane_ctrl[k].mac_first   = mac_first;
      lane_ctrl[k].chosen      = chosen_r;
      lane_ctrl[k].step        = step_r;
    end
  end

  // dimension lanes
  for (genvar g = 0; g < NDIMS; g++) begin : g_lane
    gms_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_idx (DIM_W'(g)),
      .ctrl     (lane_ctrl[g]),
      .normal   (normals[step_r]),
      .coord    (lane_coord[g]),
      .sat      (lane_sat[g])
    );
  end

  // merge: zero unused dimensions and gather the clip flags
  always_comb begin
    out_nxt.saturated = 1'b0;
    for (int k = 0; k < NDIMS; k++) begin
      if (ND_W'(k) < nd_eff) begin
        coord_used[k]     = lane_coord[k];
        out_nxt.saturated = out_nxt.saturated | lane_sat[k];
      end else begin
        coord_used[k] = '0;
      end
    end
    out_nxt.chosen_component = chosen_r;
    out_nxt.coord_0          = coord_used[0];
    out_nxt.coord_1          = coord_used[1];
    out_nxt.coord_2          = coord_used[2];
    out_nxt.coord_3          = coord_used[3];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/gms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_checker
// Port-level checks on the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gms_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  gms_pkg::gms_in_t                 in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  gms_pkg::gms_out_t                out_data
);
  import gms_pkg::*;

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // the input stalls right after a sample beat is taken
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == CMD_SAMPLE |=> in_stall)
    else $error("input taken right after a sample beat");

  // loads never block the next beat
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd != CMD_SAMPLE |=> !in_stall)
    else $error("input stalled after a load beat");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // clip flag only with a coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.coord_0 == COORD_MAX || out_data.coord_0 == COORD_MIN ||
      out_data.coord_1 == COORD_MAX || out_data.coord_1 == COORD_MIN ||
      out_data.coord_2 == COORD_MAX || out_data.coord_2 == COORD_MIN ||
      out_data.coord_3 == COORD_MAX || out_data.coord_3 == COORD_MIN)
    else $error("saturated flag without a clipped coordinate");

endmodule

bind gaussian_mixture_sampler gms_checker u_gms_checker (.*);
